// ----- src/cdf_binary_search_energy_sampler_top_assert.svh -----
// Assertion macros for the CDF binary-search energy sampler top level.
`ifndef CDF_BINARY_SEARCH_ENERGY_SAMPLER_TOP_ASSERT_SVH
`define CDF_BINARY_SEARCH_ENERGY_SAMPLER_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk and quiet in reset.
`define CDFBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cdfbs same-cycle check failed");

// Next-cycle implication, checked on clk and quiet in reset.
`define CDFBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cdfbs next-cycle check failed");

`endif

// ----- src/cdfbs_pkg.sv -----
// Shared types, constants and the search step function for the CDF energy sampler.
package cdfbs_pkg;

  localparam int MAX_CH   = 4096;
  localparam int IDX_W    = $clog2(MAX_CH);
  localparam int CNT_W    = IDX_W + 1;
  localparam int LEVELS   = $clog2(MAX_CH - 1);
  localparam int CDF_W    = 32;
  localparam int EDGE_W   = 24;
  localparam int SPREAD_W = 16;
  localparam int CHAN_W   = 12;
  localparam int PROD_W   = EDGE_W + SPREAD_W;
  // accept register, search levels, edge read, multiply, output register
  localparam int PIPE_LAT = LEVELS + 4;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 operation;
    logic [11:0]         entry_index;
    logic [CDF_W-1:0]    cdf_value;
    logic [EDGE_W-1:0]   low_edge;
    logic [EDGE_W-1:0]   high_edge;
    logic [CDF_W-1:0]    uniform_pick;
    logic [SPREAD_W-1:0] uniform_spread;
  } in_t;

  typedef struct packed {
    logic [EDGE_W-1:0] energy;
    logic [CHAN_W-1:0] channel;
    logic              beyond_total;
  } out_t;

  // One request in flight through the search levels.
  typedef struct packed {
    logic                valid;
    op_t                 op;
    logic [IDX_W-1:0]    idx;
    logic [CDF_W-1:0]    cdf;
    logic [EDGE_W-1:0]   low;
    logic [EDGE_W-1:0]   high;
    logic [CDF_W-1:0]    pick;
    logic [SPREAD_W-1:0] spread;
    logic [IDX_W-1:0]    lower;
    logic [IDX_W-1:0]    upper;
    logic [IDX_W-1:0]    mid;
    logic                act;    // a compare at mid is pending
    logic                moved;  // lower has taken a mid at least once
  } srch_t;

  // Resolve the pending compare, then pick the next midpoint.
  function automatic srch_t search_step(srch_t s, logic [CDF_W-1:0] rd);
    srch_t            r;
    logic [IDX_W:0]   sum;
    logic [IDX_W-1:0] span;
    r = s;
    if (s.act) begin
      if (rd < s.pick) begin
        r.lower = s.mid;
        r.moved = 1'b1;
      end else begin
        r.upper = s.mid;
      end
    end
    sum   = {1'b0, r.lower} + {1'b0, r.upper};
    r.mid = sum[IDX_W:1];
    span  = r.upper - r.lower;
    r.act = span > IDX_W'(1);
    return r;
  endfunction

endpackage

// ----- src/cdf_binary_search_energy_sampler_top.sv -----
// Top level of the CDF binary-search energy sampler (inverse-transform sampling).
// Path: a sample's done strobe follows its request through the accept register,
//   one stage per search level (12), the edge-table read, the multiply and the
//   output register. Loads give no result.
// Throughput: one request per clock while busy is low, loads and samples mixed in any order.
// Reset: synchronous; clears valid bits, sets channel count to 4096, holds busy
//   for one cycle; table contents stay undefined until loaded.
module cdf_binary_search_energy_sampler_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  cdfbs_pkg::in_t                req,
  input  logic                          cfg_wr_en,
  input  logic [cdfbs_pkg::CNT_W-1:0]   cfg_wr_data,
  output logic                          done,
  output cdfbs_pkg::out_t               result
);

  localparam int IDX_W = cdfbs_pkg::IDX_W;
  localparam int CDF_W = cdfbs_pkg::CDF_W;
  localparam int EDGE_W = cdfbs_pkg::EDGE_W;
  localparam int SPREAD_W = cdfbs_pkg::SPREAD_W;
  localparam int PROD_W = cdfbs_pkg::PROD_W;
  localparam int LEVELS = cdfbs_pkg::LEVELS;

  // ---------------------------------------------------------------------------
  // Channel count register and the clamped index of the last channel in use.
  // A count of zero acts as one, a count above the table depth as the depth.
  // ---------------------------------------------------------------------------
  logic [cdfbs_pkg::CNT_W-1:0] chan_cnt;
  logic [cdfbs_pkg::CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0]            last_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_cnt <= cdfbs_pkg::CNT_W'(cdfbs_pkg::MAX_CH);
    end else if (cfg_wr_en) begin
      chan_cnt <= cfg_wr_data;
    end
  end

  assign cnt_m1 = chan_cnt - cdfbs_pkg::CNT_W'(1);

  always_comb begin
    priority if (chan_cnt == '0) begin
      last_idx = '0;
    end else if (chan_cnt > cdfbs_pkg::CNT_W'(cdfbs_pkg::MAX_CH)) begin
      last_idx = IDX_W'(cdfbs_pkg::MAX_CH - 1);
    end else begin
      last_idx = cnt_m1[IDX_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Accept. The pipeline never stalls, so busy only covers the cycle after reset.
  // ---------------------------------------------------------------------------
  logic             acc;
  logic             acc_sample;
  cdfbs_pkg::srch_t st0;

  assign acc        = start && !busy;
  assign acc_sample = acc && req.operation == cdfbs_pkg::OP_SAMPLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Open the search window over [0, last channel]; no compare pending yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      st0 <= '0;
    end else begin
      st0.valid  <= acc;
      st0.op     <= req.operation;
      st0.idx    <= req.entry_index;
      st0.cdf    <= req.cdf_value;
      st0.low    <= req.low_edge;
      st0.high   <= req.high_edge;
      st0.pick   <= req.uniform_pick;
      st0.spread <= req.uniform_spread;
      st0.lower  <= '0;
      st0.upper  <= last_idx;
      st0.mid    <= '0;
      st0.act    <= 1'b0;
      st0.moved  <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Search levels. Each level owns a copy of the cumulative table; a load writes
  // each copy as it reaches that level, so every request sees the tables exactly
  // as the requests before it left them.
  // ---------------------------------------------------------------------------
  cdfbs_pkg::srch_t   lvl_st [LEVELS+1];
  logic [CDF_W-1:0]   lvl_rd [LEVELS+1];

  assign lvl_st[0] = st0;
  assign lvl_rd[0] = '0;

  for (genvar g = 0; g < LEVELS; g++) begin : g_level
    cdfbs_level u_level (
      .clk   (clk),
      .rst   (rst),
      .up    (lvl_st[g]),
      .up_rd (lvl_rd[g]),
      .dn    (lvl_st[g+1]),
      .dn_rd (lvl_rd[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Tail: resolve the last compare and pick the channel. If lower has moved, its
  // entry is already known to be below the pick, so the answer is upper; if not,
  // lower is channel 0 and its entry decides. Edge tables and the copy used for
  // the beyond-total test are written here by loads and read here by samples.
  // ---------------------------------------------------------------------------
  cdfbs_pkg::srch_t  tail;
  logic              below0;
  logic [IDX_W-1:0]  chan;
  logic [CDF_W-1:0]  cdf0;

  logic [EDGE_W-1:0] lo_mem   [cdfbs_pkg::MAX_CH];
  logic [EDGE_W-1:0] hi_mem   [cdfbs_pkg::MAX_CH];
  logic [CDF_W-1:0]  last_mem [cdfbs_pkg::MAX_CH];

  assign tail   = cdfbs_pkg::search_step(lvl_st[LEVELS], lvl_rd[LEVELS]);
  assign below0 = cdf0 < tail.pick;
  assign chan   = (tail.moved || below0) ? tail.upper : tail.lower;

  logic              e_sample;
  logic [IDX_W-1:0]  e_chan;
  logic [CDF_W-1:0]  e_pick;
  logic [SPREAD_W-1:0] e_spread;
  logic [EDGE_W-1:0] e_lo;
  logic [EDGE_W-1:0] e_hi;
  logic [CDF_W-1:0]  e_last;

  always_ff @(posedge clk) begin
    if (tail.valid && tail.op == cdfbs_pkg::OP_LOAD) begin
      lo_mem[tail.idx]   <= tail.low;
      hi_mem[tail.idx]   <= tail.high;
      last_mem[tail.idx] <= tail.cdf;
      if (tail.idx == '0) begin
        cdf0 <= tail.cdf;
      end
    end
    e_lo   <= lo_mem[chan];
    e_hi   <= hi_mem[chan];
    e_last <= last_mem[last_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_sample <= 1'b0;
    end else begin
      e_sample <= tail.valid && tail.op == cdfbs_pkg::OP_SAMPLE;
    end
    e_chan   <= chan;
    e_pick   <= tail.pick;
    e_spread <= tail.spread;
  end

  // ---------------------------------------------------------------------------
  // Energy: width times spread, registered before the add.
  // An inverted channel (high below low) returns the low edge.
  // ---------------------------------------------------------------------------
  logic              e_inv;
  logic [EDGE_W-1:0] e_diff;
  logic              e_beyond;

  assign e_inv    = e_hi < e_lo;
  assign e_diff   = e_hi - e_lo;
  assign e_beyond = e_pick > e_last;

  logic              m_valid;
  logic [PROD_W-1:0] m_prod;
  logic [EDGE_W-1:0] m_lo;
  logic              m_inv;
  logic [IDX_W-1:0]  m_chan;
  logic              m_beyond;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= e_sample;
    end
    m_prod   <= PROD_W'(e_diff) * PROD_W'(e_spread);
    m_lo     <= e_lo;
    m_inv    <= e_inv;
    m_chan   <= e_chan;
    m_beyond <= e_beyond;
  end

  // Output register: one-cycle strobe, the receiver cannot hold it off.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_valid;
    end
    result.energy       <= m_inv ? m_lo : m_lo + m_prod[PROD_W-1:SPREAD_W];
    result.channel      <= cdfbs_pkg::CHAN_W'(m_chan);
    result.beyond_total <= m_beyond;
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
`include "cdf_binary_search_energy_sampler_top_assert.svh"

  // Every strobe traces back to an accepted sample request.
  `CDFBS_ASSERT_NOW(a_latency, done, $past(acc_sample, cdfbs_pkg::PIPE_LAT))
  // The chosen channel stays inside the window being searched.
  `CDFBS_ASSERT_NOW(a_chan_range, done, result.channel <= cdfbs_pkg::CHAN_W'(last_idx))
  // The energy never falls below the channel's low edge.
  `CDFBS_ASSERT_NEXT(a_energy_floor, m_valid, result.energy >= $past(m_lo))

endmodule

// ----- src/cdfbs_level.sv -----
// One binary-search level: its own copy of the cumulative table and one stage register.
module cdfbs_level (
  input  logic                          clk,
  input  logic                          rst,
  input  cdfbs_pkg::srch_t              up,
  input  logic [cdfbs_pkg::CDF_W-1:0]   up_rd,
  output cdfbs_pkg::srch_t              dn,
  output logic [cdfbs_pkg::CDF_W-1:0]   dn_rd
);

  logic [cdfbs_pkg::CDF_W-1:0] cdf_mem [cdfbs_pkg::MAX_CH];
  cdfbs_pkg::srch_t            step;

  assign step = cdfbs_pkg::search_step(up, up_rd);

  // Loads write this copy as they pass; samples read their midpoint.
  always_ff @(posedge clk) begin
    if (up.valid && up.op == cdfbs_pkg::OP_LOAD) begin
      cdf_mem[up.idx] <= up.cdf;
    end
    dn_rd <= cdf_mem[step.mid];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn <= '0;
    end else begin
      dn <= step;
    end
  end

endmodule

// ----- test/cdf_sampler_checker.sv -----
`timescale 1ns / 100ps
// Checker for the CDF energy sampler: mirrors the tables, predicts each sample and compares.
module cdf_sampler_checker
  import cdfbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  in_t              req,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  logic             done,
  input  out_t             result,
  output int               fail_count,
  output int               waiting,
  output int               loads_seen,
  output int               samples_seen,
  output int               beyond_seen
);

  logic [CDF_W-1:0]  cdf_mem  [MAX_CH];
  logic [EDGE_W-1:0] low_mem  [MAX_CH];
  logic [EDGE_W-1:0] high_mem [MAX_CH];
  logic [CNT_W-1:0]  span_cfg;
  out_t              pending_draws [$];
  out_t              want;

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // Binary search over the active channels, then place the energy inside the channel.
  function automatic out_t draw_photon(logic [CDF_W-1:0] pick, logic [SPREAD_W-1:0] spread);
    int unsigned       n;
    int unsigned       lower;
    int unsigned       upper;
    int unsigned       mid;
    logic [EDGE_W-1:0] lo;
    logic [EDGE_W-1:0] hi;
    logic [PROD_W-1:0] part;
    out_t              r;
    n = (span_cfg == 0) ? 1 : (span_cfg > MAX_CH) ? MAX_CH : span_cfg;
    lower = 0;
    upper = n - 1;
    while (upper - lower > 1) begin
      mid = (lower + upper) / 2;
      if (cdf_mem[mid] < pick) lower = mid;
      else upper = mid;
    end
    if (cdf_mem[lower] < pick) lower = upper;
    lo = low_mem[lower];
    hi = high_mem[lower];
    part = PROD_W'(hi - lo) * PROD_W'(spread);
    r.energy       = (hi < lo) ? lo : lo + part[PROD_W-1:SPREAD_W];
    r.channel      = CHAN_W'(lower);
    r.beyond_total = pick > cdf_mem[n - 1];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      span_cfg = CNT_W'(MAX_CH);
      pending_draws.delete();
    end else begin
      // retire the oldest prediction before taking a new request on the same edge
      if (done) begin
        if (pending_draws.size() == 0) begin
          report($sformatf("result with nothing expected: energy %h channel %0d beyond %b",
                           result.energy, result.channel, result.beyond_total));
        end else begin
          want = pending_draws.pop_front();
          if (result.energy !== want.energy)
            report($sformatf("energy %h, expected %h (channel %0d)",
                             result.energy, want.energy, want.channel));
          if (result.channel !== want.channel)
            report($sformatf("channel %0d, expected %0d", result.channel, want.channel));
          if (result.beyond_total !== want.beyond_total)
            report($sformatf("beyond_total %b, expected %b (channel %0d)",
                             result.beyond_total, want.beyond_total, want.channel));
        end
      end
      if (cfg_wr_en) span_cfg = cfg_wr_data;
      if (start && !busy) begin
        if (req.operation == OP_LOAD) begin
          cdf_mem[req.entry_index]  = req.cdf_value;
          low_mem[req.entry_index]  = req.low_edge;
          high_mem[req.entry_index] = req.high_edge;
          loads_seen++;
        end else begin
          want = draw_photon(req.uniform_pick, req.uniform_spread);
          pending_draws.push_back(want);
          samples_seen++;
          if (want.beyond_total) beyond_seen++;
        end
      end
    end
    waiting <= pending_draws.size();
  end

endmodule

// ----- test/tb_cdf_binary_search_energy_sampler_top.sv -----
`timescale 1ns / 100ps
// Testbench top for the CDF energy sampler: request stimulus, watchdog and verdict.
module tb_cdf_binary_search_energy_sampler_top;
  import cdfbs_pkg::*;

  // Longest quiet stretch in a correct run is the pause around a channel-count
  // write or the final drain; allow many times that.
  localparam int STALL_LIMIT = 1000;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  in_t              req;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;
  logic             done;
  out_t             result;

  int fail_count;
  int waiting;
  int loads_seen;
  int samples_seen;
  int beyond_seen;

  // Stimulus-side copy of the cumulative table, used only to aim picks at
  // channel boundaries and to keep rewrites monotone.
  logic [CDF_W-1:0] cdf_sh [MAX_CH];
  int               filled;
  int               settings_done;
  int               idle_cycles;
  bit               calm;

  cdf_binary_search_energy_sampler_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .done        (done),
    .result      (result)
  );

  cdf_sampler_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .done         (done),
    .result       (result),
    .fail_count   (fail_count),
    .waiting      (waiting),
    .loads_seen   (loads_seen),
    .samples_seen (samples_seen),
    .beyond_seen  (beyond_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: end the run if no request is taken and no result comes for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_cdf_binary_search_energy_sampler_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request at a falling edge and hold it until the block takes it.
  // Outside calm stretches, drop start for a random number of cycles first.
  task automatic issue(in_t r);
    while (!calm && $urandom_range(99) < 25) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
  endtask

  // Load one table entry; the sample-only fields carry noise.
  task automatic send_load(logic [IDX_W-1:0] idx, logic [CDF_W-1:0] c,
                           logic [EDGE_W-1:0] lo, logic [EDGE_W-1:0] hi);
    in_t r;
    r.operation      = OP_LOAD;
    r.entry_index    = idx;
    r.cdf_value      = c;
    r.low_edge       = lo;
    r.high_edge      = hi;
    r.uniform_pick   = $urandom;
    r.uniform_spread = SPREAD_W'($urandom);
    cdf_sh[idx] = c;
    issue(r);
  endtask

  // Request one sample; the load-only fields carry noise.
  task automatic send_sample(logic [CDF_W-1:0] pick, logic [SPREAD_W-1:0] spread);
    in_t r;
    r.operation      = OP_SAMPLE;
    r.entry_index    = IDX_W'($urandom);
    r.cdf_value      = $urandom;
    r.low_edge       = EDGE_W'($urandom);
    r.high_edge      = EDGE_W'($urandom);
    r.uniform_pick   = pick;
    r.uniform_spread = spread;
    issue(r);
  endtask

  // Mostly ordered edges; sometimes inverted, zero-width or full-scale.
  task automatic pick_edges(output logic [EDGE_W-1:0] lo, output logic [EDGE_W-1:0] hi);
    int unsigned k;
    k  = $urandom_range(15);
    lo = EDGE_W'($urandom);
    if (k == 0) begin
      hi = EDGE_W'($urandom_range(lo, 0));
    end else if (k == 1) begin
      lo = '0;
      hi = '1;
    end else if (k == 2) begin
      hi = lo;
    end else begin
      hi = lo + EDGE_W'($urandom_range(24'hFFFFFF - lo, 0));
    end
  endtask

  // Write a fresh nondecreasing cumulative table over channels 0..m-1, with
  // flat runs (empty channels) and a total that is sometimes full scale.
  task automatic fill_table(int m);
    longint unsigned total;
    longint unsigned step;
    longint unsigned c;
    longint unsigned prev;
    logic [EDGE_W-1:0] lo;
    logic [EDGE_W-1:0] hi;
    total = ($urandom_range(3) == 0) ? 64'hFFFF_FFFF
                                     : $urandom_range(32'hFFFF_FFFE, 32'h8000_0000);
    step  = total / m;
    prev  = 0;
    for (int i = 0; i < m; i++) begin
      if (i > 0 && $urandom_range(7) == 0) c = prev;
      else c = (i + 1) * step + $urandom_range(step - 1, 0);
      if (c > 64'hFFFF_FFFF) c = 64'hFFFF_FFFF;
      pick_edges(lo, hi);
      send_load(IDX_W'(i), c[CDF_W-1:0], lo, hi);
      prev = c;
    end
    if (m > filled) filled = m;
  endtask

  // Drain everything in flight, wait out trailing loads, then write the count.
  task automatic set_channels(logic [CNT_W-1:0] v);
    @(negedge clk);
    start <= 1'b0;
    while (waiting != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_done++;
  endtask

  // One setting of the channel count followed by a random mix of samples and
  // table rewrites. Samples dominate; rewrites mostly keep the table monotone.
  task automatic run_phase(logic [CNT_W-1:0] cnt, int draws, bit no_gaps);
    int                n_eff;
    int                drawn;
    int                i;
    int unsigned       k;
    logic [CDF_W-1:0]  pick;
    logic [CDF_W-1:0]  lo_b;
    logic [CDF_W-1:0]  hi_b;
    logic [EDGE_W-1:0] lo;
    logic [EDGE_W-1:0] hi;
    set_channels(cnt);
    calm  = no_gaps;
    n_eff = (cnt == 0) ? 1 : (cnt > MAX_CH) ? MAX_CH : cnt;
    // small tables are rebuilt every phase; large ones are written once and reused
    if (n_eff <= 256 || filled < n_eff) fill_table(n_eff);
    drawn = 0;
    while (drawn < draws) begin
      k = $urandom_range(9);
      i = $urandom_range(n_eff - 1);
      if (k < 2) begin
        pick_edges(lo, hi);
        if ($urandom_range(9) < 7) begin
          // rewrite one active entry between its neighbors
          lo_b = (i == 0) ? '0 : cdf_sh[i - 1];
          hi_b = (i == n_eff - 1) ? '1 : cdf_sh[i + 1];
          send_load(IDX_W'(i), $urandom_range(hi_b, lo_b), lo, hi);
        end else begin
          // noise load anywhere in the table
          send_load(IDX_W'($urandom), $urandom, lo, hi);
        end
      end else begin
        k = $urandom_range(99);
        if (k < 50) pick = $urandom;
        else if (k < 70) pick = cdf_sh[i];
        else if (k < 80) pick = cdf_sh[i] + 1;
        else if (k < 88) pick = cdf_sh[i] - 1;
        else if (k < 95)
          pick = (cdf_sh[n_eff - 1] == '1) ? '1
                 : $urandom_range(32'hFFFF_FFFF, cdf_sh[n_eff - 1] + 1);
        else pick = k[0] ? '1 : '0;
        send_sample(pick, SPREAD_W'($urandom));
        drawn++;
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    req         = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    calm        = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: four channels with a zero first value, an inverted channel and
    // a zero-width channel; picks at zero, on a boundary, just past it and past
    // the total, with the spread at both ends.
    set_channels(CNT_W'(4));
    send_load(IDX_W'(0), 32'h0000_0000, 24'h000000, 24'hFFFFFF);
    send_load(IDX_W'(1), 32'h4000_0000, 24'h010000, 24'h020000);
    send_load(IDX_W'(2), 32'h8000_0000, 24'hFFFFFF, 24'h000000);
    send_load(IDX_W'(3), 32'hC000_0000, 24'h100000, 24'h100000);
    send_load(IDX_W'(4095), 32'hFFFF_FFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_sample(32'h0000_0000, 16'hFFFF);
    send_sample(32'h0000_0001, 16'h0000);
    send_sample(32'h4000_0000, 16'h8000);
    send_sample(32'h7FFF_FFFF, 16'hFFFF);
    send_sample(32'h8000_0001, 16'h1234);
    send_sample(32'hFFFF_FFFF, 16'hFFFF);
    // a zero count acts as a single channel
    set_channels(CNT_W'(0));
    send_sample(32'h0000_0000, 16'h0000);
    send_sample(32'hFFFF_FFFF, 16'h8000);
    // two channels: no search step at all; a pick equal to the total is not beyond it
    set_channels(CNT_W'(2));
    send_load(IDX_W'(1), 32'hFFFF_FFFF, 24'h000000, 24'hFFFFFF);
    send_sample(32'hFFFF_FFFF, 16'hFFFF);
    send_sample(32'h8000_0000, 16'h0001);

    // Random phases over small and mid-size tables; each table is rebuilt when
    // its phase starts, and the largest one runs with no gaps at all.
    run_phase(CNT_W'(5), 50, 1'b0);
    run_phase(CNT_W'(2), 30, 1'b0);
    run_phase(CNT_W'(17), 50, 1'b1);
    run_phase(CNT_W'(1), 20, 1'b0);
    run_phase(CNT_W'(64), 60, 1'b0);
    run_phase(CNT_W'(0), 20, 1'b0);
    run_phase(CNT_W'(3), 40, 1'b0);
    run_phase(CNT_W'(100), 60, 1'b1);

    // Drop start, let every sample come back, then watch for stray results.
    @(negedge clk);
    start <= 1'b0;
    while (waiting != 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);

    $display("Run covered %0d table loads and %0d samples, %0d of them past the total,",
             loads_seen, samples_seen, beyond_seen);
    $display("across %0d channel-count writes from 0 up to 100.", settings_done);
    if (fail_count == 0) begin
      $display("tb_cdf_binary_search_energy_sampler_top passed");
    end else begin
      $display("tb_cdf_binary_search_energy_sampler_top failed");
    end
    $finish;
  end

endmodule
